>>> design/spool_pkg.sv
`default_nettype none

package spool_pkg;

	// Fixed width of the slot fields on the ports
	localparam int unsigned SLOT_FIELD_W = 9;

	// Command codes
	localparam logic CMD_ALLOC   = 1'b0;
	localparam logic CMD_RELEASE = 1'b1;

	// Status codes
	localparam logic ST_OK         = 1'b0;
	localparam logic ST_NOT_ACTIVE = 1'b1;

	// Sequencer states, one-hot
	typedef enum logic [7:0] {
		S_IDLE    = 8'b0000_0001,
		S_READ    = 8'b0000_0010,
		S_EVICT   = 8'b0000_0100,
		S_ALLOC_A = 8'b0000_1000,
		S_ALLOC_B = 8'b0001_0000,
		S_REL_CHK = 8'b0010_0000,
		S_REL_FIN = 8'b0100_0000,
		S_DONE    = 8'b1000_0000
	} seq_state_t;

	// One result word
	typedef struct packed {
		logic [SLOT_FIELD_W-1:0] granted_slot;
		logic                    evicted;
		logic [SLOT_FIELD_W-1:0] evicted_slot;
		logic                    status;
	} result_t;

endpackage

`default_nettype wire

>>> design/spool_ram.sv
`default_nettype none

module spool_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic                     we,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rd_q <= mem[addr];
	end

	assign rdata = rd_q;

endmodule

`default_nettype wire

>>> design/spool_sweep.sv
`default_nettype none

// Clearing pass after reset: walk every entry once, one per cycle.
module spool_sweep #(
	parameter int unsigned SLOT_COUNT = 512
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	output logic                                     busy,
	output logic [$clog2(SLOT_COUNT)-1:0]            addr,
	output logic [$clog2(SLOT_COUNT+1)-1:0]          next_init
);

	localparam int unsigned AW = $clog2(SLOT_COUNT);
	localparam int unsigned LW = $clog2(SLOT_COUNT + 1);

	logic [AW-1:0] cnt_q;
	logic          busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b1;
		end else if (busy_q) begin
			if (cnt_q == AW'(SLOT_COUNT - 1)) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q + AW'(1);
			end
		end
	end

	assign busy      = busy_q;
	assign addr      = cnt_q;
	// last entry links to the end marker, which equals SLOT_COUNT
	assign next_init = LW'(cnt_q) + LW'(1);

endmodule

`default_nettype wire

>>> design/slot_pool_with_oldest_eviction_top.sv
`default_nettype none

// Slot pool with a free list and an age-ordered active list.
// Input channel (in_valid / in_stall): one command word, command plus
// slot_index. Allocate pops the free-list head and links it in as the
// youngest active slot; with the free list empty it first reclaims the
// oldest active slot and reports it in evicted / evicted_slot. Release
// unlinks the named slot and pushes it back on the free list; releasing a
// slot that is not active returns status 1 and changes nothing.
// Output channel (out_valid / out_stall): exactly one result word per command.
// Steps: allocate S_READ, S_ALLOC_A, S_ALLOC_B, S_DONE, with S_EVICT after
// S_READ when it evicts; release S_READ, S_REL_CHK, S_REL_FIN, S_DONE, where
// an inactive slot skips S_REL_FIN and an index beyond the pool goes from
// S_READ to S_DONE. The next command is taken at the earliest at the edge
// at which the result word can be taken; the steps are set by the dependent
// read-then-write steps on the single-port link memories.
// Reset: a clearing pass over all SLOT_COUNT entries rebuilds the free list and
// clears the active bits; in_stall stays high until it ends.
// Stall: a finished word waits in the output register, and the next command
// is already taken and worked on; it completes once that word is taken.
module slot_pool_with_oldest_eviction_top
	import spool_pkg::*;
#(
	parameter int unsigned SLOT_COUNT = 512
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    in_valid,
	output logic                         in_stall,
	input  wire logic                    command,
	input  wire logic [SLOT_FIELD_W-1:0] slot_index,
	output logic                         out_valid,
	input  wire logic                    out_stall,
	output logic      [SLOT_FIELD_W-1:0] granted_slot,
	output logic                         evicted,
	output logic      [SLOT_FIELD_W-1:0] evicted_slot,
	output logic                         status
);

	localparam int unsigned AW = $clog2(SLOT_COUNT);
	localparam int unsigned LW = $clog2(SLOT_COUNT + 1);
	localparam logic [LW-1:0] NONE = LW'(SLOT_COUNT);

	// Clearing pass
	logic          sweep_busy;
	logic [AW-1:0] sweep_addr;
	logic [LW-1:0] sweep_next;

	spool_sweep #(.SLOT_COUNT(SLOT_COUNT)) u_sweep (
		.clk       (clk),
		.arst_n    (arst_n),
		.busy      (sweep_busy),
		.addr      (sweep_addr),
		.next_init (sweep_next)
	);

	// Link memories: next link alone, and {active, prev link}
	logic [AW-1:0] nxt_addr, pa_addr;
	logic          nxt_we, pa_we;
	logic [LW-1:0] nxt_wdata, nxt_rdata;
	logic [LW:0]   pa_wdata, pa_rdata;

	spool_ram #(.WIDTH(LW), .DEPTH(SLOT_COUNT)) u_next_ram (
		.clk   (clk),
		.addr  (nxt_addr),
		.we    (nxt_we),
		.wdata (nxt_wdata),
		.rdata (nxt_rdata)
	);

	spool_ram #(.WIDTH(LW + 1), .DEPTH(SLOT_COUNT)) u_prev_ram (
		.clk   (clk),
		.addr  (pa_addr),
		.we    (pa_we),
		.wdata (pa_wdata),
		.rdata (pa_rdata)
	);

	// Sequencer and list registers
	seq_state_t    state_q;
	logic          cmd_q;
	logic          idx_ok_q;
	logic [LW-1:0] idx_q;
	logic [LW-1:0] slot_q;
	logic          evict_q;
	logic [LW-1:0] free_head_q;
	logic [LW-1:0] youngest_q;
	logic [LW-1:0] oldest_q;
	result_t       res_q;
	result_t       out_q;
	logic          out_valid_q;

	logic          in_take;
	logic          out_take;
	logic          out_load;
	logic [16:0]   idx_wide;
	logic [LW-1:0] pa_prev;
	logic          pa_active;

	assign in_stall  = sweep_busy || (state_q != S_IDLE);
	assign in_take   = in_valid && !in_stall;
	assign out_take  = out_valid_q && !out_stall;
	assign out_load  = (state_q == S_DONE) && (!out_valid_q || !out_stall);
	assign idx_wide  = 17'(slot_index);
	assign pa_prev   = pa_rdata[LW-1:0];
	assign pa_active = pa_rdata[LW];

	// Memory port selection
	always_comb begin
		nxt_addr  = '0;
		nxt_we    = 1'b0;
		nxt_wdata = '0;
		pa_addr   = '0;
		pa_we     = 1'b0;
		pa_wdata  = '0;
		if (sweep_busy) begin
			nxt_addr  = sweep_addr;
			nxt_we    = 1'b1;
			nxt_wdata = sweep_next;
			pa_addr   = sweep_addr;
			pa_we     = 1'b1;
			pa_wdata  = {1'b0, NONE};
		end else begin
			case (state_q)
				S_READ: begin
					if (cmd_q == CMD_RELEASE) begin
						nxt_addr = idx_q[AW-1:0];
						pa_addr  = idx_q[AW-1:0];
					end else begin
						nxt_addr = free_head_q[AW-1:0];
						pa_addr  = oldest_q[AW-1:0];
					end
				end
				S_EVICT: begin
					// detach the reclaimed slot from its younger neighbour
					nxt_addr  = pa_prev[AW-1:0];
					nxt_we    = (pa_prev != NONE);
					nxt_wdata = NONE;
				end
				S_ALLOC_A: begin
					nxt_addr  = slot_q[AW-1:0];
					nxt_we    = 1'b1;
					nxt_wdata = youngest_q;
					pa_addr   = slot_q[AW-1:0];
					pa_we     = 1'b1;
					pa_wdata  = {1'b1, NONE};
				end
				S_ALLOC_B: begin
					pa_addr  = youngest_q[AW-1:0];
					pa_we    = (youngest_q != NONE);
					pa_wdata = {1'b1, slot_q};
				end
				S_REL_CHK: begin
					// bridge the neighbours over the released slot
					nxt_addr  = pa_prev[AW-1:0];
					nxt_we    = pa_active && (pa_prev != NONE);
					nxt_wdata = nxt_rdata;
					pa_addr   = nxt_rdata[AW-1:0];
					pa_we     = pa_active && (nxt_rdata != NONE);
					pa_wdata  = {1'b1, pa_prev};
				end
				S_REL_FIN: begin
					nxt_addr  = slot_q[AW-1:0];
					nxt_we    = 1'b1;
					nxt_wdata = free_head_q;
					pa_addr   = slot_q[AW-1:0];
					pa_we     = 1'b1;
					pa_wdata  = {1'b0, NONE};
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			free_head_q <= '0;
			youngest_q  <= NONE;
			oldest_q    <= NONE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_take && !out_load) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_take) begin
						state_q <= S_READ;
					end
				end
				S_READ: begin
					if (cmd_q == CMD_RELEASE) begin
						state_q <= idx_ok_q ? S_REL_CHK : S_DONE;
					end else if (free_head_q != NONE) begin
						state_q <= S_ALLOC_A;
					end else if (oldest_q != NONE) begin
						state_q <= S_EVICT;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_EVICT: begin
					// the oldest slot has no older neighbour
					oldest_q <= pa_prev;
					if (pa_prev == NONE) begin
						youngest_q <= NONE;
					end
					state_q <= S_ALLOC_A;
				end
				S_ALLOC_A: begin
					// after an eviction the free list is empty again
					if (!evict_q) begin
						free_head_q <= nxt_rdata;
					end
					state_q <= S_ALLOC_B;
				end
				S_ALLOC_B: begin
					if (youngest_q == NONE) begin
						oldest_q <= slot_q;
					end
					youngest_q <= slot_q;
					state_q    <= S_DONE;
				end
				S_REL_CHK: begin
					if (pa_active) begin
						if (pa_prev == NONE) begin
							youngest_q <= nxt_rdata;
						end
						if (nxt_rdata == NONE) begin
							oldest_q <= pa_prev;
						end
						state_q <= S_REL_FIN;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_REL_FIN: begin
					free_head_q <= slot_q;
					state_q     <= S_DONE;
				end
				S_DONE: begin
					if (out_load) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (in_take) begin
			cmd_q    <= command;
			idx_ok_q <= (idx_wide < 17'(SLOT_COUNT));
			idx_q    <= LW'(idx_wide);
			res_q    <= '0;
		end
		case (state_q)
			S_READ: begin
				if (cmd_q == CMD_RELEASE) begin
					slot_q <= idx_q;
					if (!idx_ok_q) begin
						res_q.status <= ST_NOT_ACTIVE;
					end
				end else if (free_head_q != NONE) begin
					slot_q  <= free_head_q;
					evict_q <= 1'b0;
				end else begin
					slot_q             <= oldest_q;
					evict_q            <= 1'b1;
					res_q.evicted      <= (oldest_q != NONE);
					res_q.evicted_slot <= SLOT_FIELD_W'(oldest_q);
				end
			end
			S_ALLOC_B: begin
				res_q.granted_slot <= SLOT_FIELD_W'(slot_q);
			end
			S_REL_CHK: begin
				if (!pa_active) begin
					res_q.status <= ST_NOT_ACTIVE;
				end
			end
			default: begin
			end
		endcase
		if (out_load) begin
			out_q <= res_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign granted_slot = out_q.granted_slot;
	assign evicted      = out_q.evicted;
	assign evicted_slot = out_q.evicted_slot;
	assign status       = out_q.status;

endmodule

`default_nettype wire

>>> tb/slot_pool_with_oldest_eviction_top_tb.sv
module slot_pool_with_oldest_eviction_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import spool_pkg::*;

	localparam int unsigned POOL_SIZE = 512;
	// End-of-list marker, one past the last slot
	localparam int unsigned NO_SLOT = POOL_SIZE;
	localparam int unsigned WORDS_PER_PHASE = 580;
	// Settle time after the last word: eviction latency plus margin
	localparam int unsigned SETTLE_CYCLES = 20;

	// Clock, reset and the two channels
	logic                    clk;
	logic                    arst_n = 1'b0;
	logic                    in_valid = 1'b0;
	logic                    in_stall;
	logic                    command = CMD_ALLOC;
	logic [SLOT_FIELD_W-1:0] slot_index = '0;
	logic                    out_valid;
	logic                    out_stall = 1'b0;
	logic [SLOT_FIELD_W-1:0] granted_slot;
	logic                    evicted;
	logic [SLOT_FIELD_W-1:0] evicted_slot;
	logic                    status;

	// Idling odds in percent, changed by the stimulus process per phase
	int unsigned send_idle_pct = 27;
	int unsigned recv_stall_pct = 45;

	int unsigned mismatches = 0;
	int unsigned results_seen = 0;
	int unsigned evictions_seen = 0;
	int unsigned refusals_seen = 0;
	int unsigned allocs_sent = 0;
	int unsigned releases_sent = 0;

	// Results still owed by the block, oldest first
	result_t pending_results[$];

	// Shadow copy of the pool: older_of doubles as the free-list link
	int unsigned older_of[POOL_SIZE];
	int unsigned younger_of[POOL_SIZE];
	bit          in_use[POOL_SIZE];
	int unsigned free_top;
	int unsigned young_end;
	int unsigned old_end;

	slot_pool_with_oldest_eviction_top #(
		.SLOT_COUNT(POOL_SIZE)
	) i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.command     (command),
		.slot_index  (slot_index),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.granted_slot(granted_slot),
		.evicted     (evicted),
		.evicted_slot(evicted_slot),
		.status      (status)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Hard stop in case the block hangs: far beyond the slowest correct run
	initial begin
		#2_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	function automatic void pool_reset();
		for (int unsigned i = 0; i < POOL_SIZE; i++) begin
			older_of[i] = i + 1;
			younger_of[i] = NO_SLOT;
			in_use[i] = 1'b0;
		end
		free_top = 0;
		young_end = NO_SLOT;
		old_end = NO_SLOT;
	endfunction

	// Unlink a slot from the age list and push it onto the free list
	function automatic void retire_slot(int unsigned s);
		int unsigned younger;
		int unsigned older;
		younger = younger_of[s];
		older = older_of[s];
		if (younger < NO_SLOT)
			older_of[younger] = older;
		else
			young_end = older;
		if (older < NO_SLOT)
			younger_of[older] = younger;
		else
			old_end = younger;
		older_of[s] = free_top;
		younger_of[s] = NO_SLOT;
		in_use[s] = 1'b0;
		free_top = s;
	endfunction

	// Apply one command to the shadow pool and return the word it yields
	function automatic result_t pool_apply(logic cmd, logic [SLOT_FIELD_W-1:0] idx);
		result_t     r;
		int unsigned s;
		r = '{granted_slot: '0, evicted: 1'b0, evicted_slot: '0, status: ST_OK};
		if (cmd == CMD_ALLOC) begin
			if (free_top >= NO_SLOT && old_end < NO_SLOT) begin
				r.evicted = 1'b1;
				r.evicted_slot = old_end[SLOT_FIELD_W-1:0];
				retire_slot(old_end);
			end
			if (free_top < NO_SLOT) begin
				s = free_top;
				free_top = older_of[s];
				older_of[s] = young_end;
				younger_of[s] = NO_SLOT;
				if (young_end < NO_SLOT)
					younger_of[young_end] = s;
				else
					old_end = s;
				young_end = s;
				in_use[s] = 1'b1;
				r.granted_slot = s[SLOT_FIELD_W-1:0];
			end
		end else begin
			if (idx < NO_SLOT && in_use[idx])
				retire_slot(idx);
			else
				r.status = ST_NOT_ACTIVE;
		end
		return r;
	endfunction

	// Pick an active slot at random, or -1 when none is active
	function automatic int pick_live_slot();
		int unsigned start;
		start = $urandom_range(POOL_SIZE - 1);
		for (int unsigned k = 0; k < POOL_SIZE; k++)
			if (in_use[(start + k) % POOL_SIZE])
				return (start + k) % POOL_SIZE;
		return -1;
	endfunction

	task automatic report_mismatch(string what, int unsigned got, int unsigned want);
		mismatches++;
		$display("[%0t] result %0d: %s got %0d, want %0d", $realtime, results_seen, what,
			got, want);
	endtask

	// Offer one command word, hold it through stalls, and log what it must yield.
	// Typed rows carry their own expected word; the shadow pool still advances.
	task automatic send_word(logic cmd, logic [SLOT_FIELD_W-1:0] idx, bit typed,
			result_t want);
		result_t model;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		command    <= cmd;
		slot_index <= idx;
		do
			@(posedge clk);
		while (in_stall);
		model = pool_apply(cmd, idx);
		pending_results.push_back(typed ? want : model);
		if (cmd == CMD_ALLOC)
			allocs_sent++;
		else
			releases_sent++;
	endtask

	// Output side: check each accepted word and stall at random.
	// Values read here are the ones from before the edge, so there is no race
	// with the block's own registers.
	always @(posedge clk) begin : rx
		result_t want;
		if (out_valid === 1'b1 && !out_stall) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				report_mismatch("word with nothing expected, granted_slot", granted_slot, 0);
			end else begin
				want = pending_results.pop_front();
				if (granted_slot !== want.granted_slot)
					report_mismatch("granted_slot", granted_slot, want.granted_slot);
				if (evicted !== want.evicted)
					report_mismatch("evicted", evicted, want.evicted);
				if (evicted_slot !== want.evicted_slot)
					report_mismatch("evicted_slot", evicted_slot, want.evicted_slot);
				if (status !== want.status)
					report_mismatch("status", status, want.status);
				if (want.evicted)
					evictions_seen++;
				if (want.status == ST_NOT_ACTIVE)
					refusals_seen++;
			end
		end
		out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	typedef struct {
		logic                    cmd;
		logic [SLOT_FIELD_W-1:0] idx;
		bit                      typed;
		result_t                 want;
	} probe_t;

	localparam result_t NO_WORD = '{granted_slot: '0, evicted: 1'b0, evicted_slot: '0,
		status: ST_OK};
	localparam result_t REFUSED = '{granted_slot: '0, evicted: 1'b0, evicted_slot: '0,
		status: ST_NOT_ACTIVE};

	// Directed opening. Slot numbers in the comments follow from the free list
	// order after reset: 0, 1, 2, ... with released slots pushed on top.
	probe_t probes[20] = '{
		'{CMD_ALLOC,   9'd0,   1'b1, NO_WORD},  // first allocate after reset hands out slot 0
		'{CMD_RELEASE, 9'd0,   1'b1, NO_WORD},  // release the only active slot
		'{CMD_RELEASE, 9'd0,   1'b1, REFUSED},  // double free
		'{CMD_RELEASE, 9'd511, 1'b1, REFUSED},  // top slot, never allocated
		'{CMD_RELEASE, 9'd1,   1'b1, REFUSED},  // never allocated
		'{CMD_ALLOC,   9'd511, 1'b0, NO_WORD},  // index ignored on allocate: all ones
		'{CMD_ALLOC,   9'd0,   1'b0, NO_WORD},
		'{CMD_ALLOC,   9'h0AA, 1'b0, NO_WORD},
		'{CMD_ALLOC,   9'h155, 1'b0, NO_WORD},  // active, young to old: 3 2 1 0
		'{CMD_RELEASE, 9'd1,   1'b0, NO_WORD},  // unlink from the middle
		'{CMD_RELEASE, 9'd3,   1'b0, NO_WORD},  // unlink the youngest
		'{CMD_RELEASE, 9'd0,   1'b0, NO_WORD},  // unlink the oldest
		'{CMD_RELEASE, 9'd3,   1'b1, REFUSED},  // double free of the old youngest
		'{CMD_RELEASE, 9'd2,   1'b0, NO_WORD},  // empties the active list
		'{CMD_ALLOC,   9'd0,   1'b0, NO_WORD},
		'{CMD_ALLOC,   9'd0,   1'b0, NO_WORD},
		'{CMD_RELEASE, 9'h1FE, 1'b1, REFUSED},
		'{CMD_RELEASE, 9'h100, 1'b1, REFUSED},
		'{CMD_ALLOC,   9'h1FF, 1'b0, NO_WORD},
		'{CMD_RELEASE, 9'h0FF, 1'b1, REFUSED}
	};

	initial begin : stimulus
		int unsigned alloc_pct;
		int unsigned roll;
		int          live;

		pool_reset();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// The block holds in_stall through its clearing pass; send_word waits it out
		foreach (probes[i])
			send_word(probes[i].cmd, probes[i].idx, probes[i].typed, probes[i].want);

		// Random part in three phases. The first fills most of the pool, the second
		// churns it full so that most allocates evict, the third shrinks it again.
		// About one word in twenty-five is a release of a random index.
		for (int ph = 0; ph < 3; ph++) begin
			case (ph)
				0: begin
					send_idle_pct = 27;
					recv_stall_pct = 45;
					alloc_pct = 85;
				end
				1: begin
					send_idle_pct = 45;
					recv_stall_pct = 27;
					alloc_pct = 70;
				end
				default: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
					alloc_pct = 40;
				end
			endcase
			for (int n = 0; n < WORDS_PER_PHASE; n++) begin
				roll = $urandom_range(99);
				live = pick_live_slot();
				if (roll >= 96)
					send_word(CMD_RELEASE, SLOT_FIELD_W'($urandom), 1'b0, NO_WORD);
				else if (roll < alloc_pct || live < 0)
					send_word(CMD_ALLOC, SLOT_FIELD_W'($urandom), 1'b0, NO_WORD);
				else
					send_word(CMD_RELEASE, live[SLOT_FIELD_W-1:0], 1'b0, NO_WORD);
			end
		end
		in_valid <= 1'b0;

		// Drain what is owed, then give stray words time to show up
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Covered %0d allocates and %0d releases, %0d result words checked.",
			allocs_sent, releases_sent, results_seen);
		$display("Saw %0d evictions of the oldest slot and %0d refused releases.",
			evictions_seen, refusals_seen);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
